FILE: rtl/core/cfs_pkg.sv
`timescale 1ns / 1ps

package cfs_pkg;

	localparam int VALUE_W = 32;
	localparam int CNT_W   = 5;
	localparam int CAP_W   = 5;

	typedef enum logic [1:0] {
		OP_ENQ    = 2'd0,
		OP_DEQ    = 2'd1,
		OP_PEEK   = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_WALK = 2'd1,
		S_DONE = 2'd2
	} state_t;

	typedef struct packed {
		op_t                operation;
		logic [VALUE_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] data;
		logic               found;
		logic [CNT_W-1:0]   occupancy;
	} out_item_t;

	typedef struct packed {
		logic valid;
		logic hit;
	} srch_flags_t;

endpackage

FILE: rtl/core/circular_fifo_with_search_core.sv
`timescale 1ns / 1ps

// Circular FIFO with search, built as a row of DEPTH cells ordered from head
// to tail. Enqueue writes the cell just past the last occupied one; dequeue
// shifts every cell one place towards the head. For enqueue, dequeue and
// peek, the result is in the output register on the cycle after the item is
// accepted. A search sends the key down the row, one cell per cycle; no other
// item is accepted while it runs. Writing the capacity register (0 acts as 1,
// values above DEPTH act as DEPTH) empties the queue; write it only while the
// block is idle.
module circular_fifo_with_search_core import cfs_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             capacity_we,
	input  logic [CAP_W-1:0] capacity_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item
);

	localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CAP_W-1:0] capacity_q;
	logic             hit_q;
	logic             out_valid_q;
	out_item_t        out_q;
	out_item_t        res;
	logic             launch_q;
	logic [DATA_WIDTH-1:0] launch_key_q;

	logic                  accept;
	logic                  out_free;
	logic                  load_out;
	logic                  enq_ok;
	logic                  deq_ok;
	logic                  launch;
	logic [DATA_WIDTH-1:0] key_w;
	logic [CAP_W-1:0]      cap_clamped;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] key_link  [DEPTH+1];
	srch_flags_t           flags_link [DEPTH+1];

	assign out_free = !(out_valid_q && out_stall);
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;
	assign key_w    = DATA_WIDTH'(in_item.value);
	assign enq_ok   = accept && (in_item.operation == OP_ENQ) && (count_q < capacity_q);
	assign deq_ok   = accept && (in_item.operation == OP_DEQ) && (count_q != '0);
	assign launch   = accept && (in_item.operation == OP_SEARCH);

	always_comb begin
		if (capacity_wdata == '0) begin
			cap_clamped = CAP_W'(1);
		end else if (32'(capacity_wdata) > CAP_MAX) begin
			cap_clamped = CAP_W'(CAP_MAX);
		end else begin
			cap_clamped = capacity_wdata;
		end
	end

	always_comb begin
		count_d = count_q;
		if (enq_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (deq_ok) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		res      = '0;
		res.occupancy = count_d;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_item.operation)
						OP_ENQ: begin
							res.status = (count_q < capacity_q) ? ST_OK : ST_FULL;
							load_out   = 1'b1;
						end
						OP_DEQ, OP_PEEK: begin
							if (count_q == '0) begin
								res.status = ST_EMPTY;
							end else begin
								res.data = VALUE_W'(cell_data[0]);
							end
							load_out = 1'b1;
						end
						default: begin
							state_d = S_WALK;
						end
					endcase
				end
			end
			S_WALK: begin
				if (flags_link[DEPTH].valid) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				res.found = hit_q;
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			capacity_q  <= CAP_W'(CAP_MAX);
			out_valid_q <= 1'b0;
			launch_q    <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= launch;
			if (capacity_we) begin
				capacity_q <= cap_clamped;
				count_q    <= '0;
			end else begin
				count_q <= count_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_WALK && flags_link[DEPTH].valid) begin
				hit_q <= flags_link[DEPTH].hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res;
		end
		if (launch) begin
			launch_key_q <= key_w;
		end
	end

	assign key_link[0]         = launch_key_q;
	assign flags_link[0].valid = launch_q;
	assign flags_link[0].hit   = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] next_data;
		if (i == DEPTH - 1) begin : g_last
			assign next_data = '0;
		end else begin : g_mid
			assign next_data = cell_data[i+1];
		end

		cfs_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.occupied   (32'(count_q) > i),
			.load_en    (enq_ok && (32'(count_q) == i)),
			.load_data  (key_w),
			.shift_en   (deq_ok),
			.shift_data (next_data),
			.data       (cell_data[i]),
			.key_in     (key_link[i]),
			.flags_in   (flags_link[i]),
			.key_out    (key_link[i+1]),
			.flags_out  (flags_link[i+1])
		);
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

FILE: rtl/core/cfs_cell.sv
`timescale 1ns / 1ps

module cfs_cell import cfs_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  occupied,
	input  logic                  load_en,
	input  logic [DATA_WIDTH-1:0] load_data,
	input  logic                  shift_en,
	input  logic [DATA_WIDTH-1:0] shift_data,
	output logic [DATA_WIDTH-1:0] data,
	input  logic [DATA_WIDTH-1:0] key_in,
	input  srch_flags_t           flags_in,
	output logic [DATA_WIDTH-1:0] key_out,
	output srch_flags_t           flags_out
);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] key_s1;
	srch_flags_t           flags_s1;

	always_ff @(posedge clk) begin
		if (load_en) begin
			data_q <= load_data;
		end else if (shift_en) begin
			data_q <= shift_data;
		end
		key_s1 <= key_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s1 <= '0;
		end else begin
			flags_s1.valid <= flags_in.valid;
			flags_s1.hit   <= flags_in.hit
				| (flags_in.valid & occupied & (key_in == data_q));
		end
	end

	assign data      = data_q;
	assign key_out   = key_s1;
	assign flags_out = flags_s1;

endmodule

FILE: rtl/core/cfs_checker.sv
`timescale 1ns / 1ps

module cfs_checker import cfs_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input in_item_t         in_item,
	input logic             out_valid,
	input logic             out_stall,
	input out_item_t        out_item
);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_item.occupancy) <= DEPTH)
		else $error("occupancy beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_EMPTY |->
			out_item.occupancy == '0 && out_item.data == '0 && !out_item.found)
		else $error("bad empty result");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_FULL |->
			out_item.occupancy != '0 && out_item.data == '0 && !out_item.found)
		else $error("bad full result");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.operation == OP_SEARCH |=> in_stall)
		else $error("item taken during search");

endmodule

bind circular_fifo_with_search_core cfs_checker #(.DEPTH(DEPTH)) u_cfs_checker (.*);

FILE: test/fifo_search_checker.sv
`timescale 1ns / 1ps

module fifo_search_checker import cfs_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             capacity_we,
	input  logic [CAP_W-1:0] capacity_wdata,
	input  logic             in_valid,
	input  logic             in_stall,
	input  in_item_t         in_item,
	input  logic             out_valid,
	input  logic             out_stall,
	input  out_item_t        out_item,
	output int               mismatches,
	output int               outstanding
);

	localparam int PTR_W = $clog2(DEPTH);

	logic [VALUE_W-1:0] slot_mem [DEPTH];
	logic [PTR_W-1:0]   head_ptr;
	logic [PTR_W-1:0]   tail_ptr;
	logic [CNT_W-1:0]   held;
	logic [CAP_W-1:0]   cap;
	out_item_t          awaited_results [$];
	int                 error_tally = 0;

	function automatic logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
		logic [PTR_W:0] n;
		n = {1'b0, p} + 1'b1;
		if (n >= cap || n >= DEPTH)
			return '0;
		return n[PTR_W-1:0];
	endfunction

	function automatic out_item_t predict_queue_op(in_item_t it);
		out_item_t        r;
		logic [PTR_W-1:0] p;
		r = '0;
		r.status = ST_OK;
		case (it.operation)
			OP_ENQ: begin
				if (held >= cap) begin
					r.status = ST_FULL;
				end else begin
					slot_mem[tail_ptr] = it.value;
					tail_ptr = step_ptr(tail_ptr);
					held++;
				end
			end
			OP_DEQ, OP_PEEK: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.data = slot_mem[head_ptr];
					if (it.operation == OP_DEQ) begin
						head_ptr = step_ptr(head_ptr);
						held--;
					end
				end
			end
			OP_SEARCH: begin
				p = head_ptr;
				for (int k = 0; k < held; k++) begin
					if (slot_mem[p] == it.value)
						r.found = 1'b1;
					p = step_ptr(p);
				end
			end
		endcase
		r.occupancy = held;
		return r;
	endfunction

	task automatic check_field(string name, logic [VALUE_W-1:0] e, logic [VALUE_W-1:0] a);
		if (a !== e) begin
			error_tally++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			head_ptr = '0;
			tail_ptr = '0;
			held = '0;
			cap = CAP_W'(DEPTH);
			awaited_results.delete();
		end else begin
			if (capacity_we) begin
				if (capacity_wdata == '0)
					cap = CAP_W'(1);
				else if (capacity_wdata > DEPTH)
					cap = CAP_W'(DEPTH);
				else
					cap = capacity_wdata;
				head_ptr = '0;
				tail_ptr = '0;
				held = '0;
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(predict_queue_op(in_item));
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					error_tally++;
					$display("%0t: unexpected item, expected none actual %p", $time, out_item);
				end else begin
					want = awaited_results.pop_front();
					check_field("status", want.status, out_item.status);
					check_field("data", want.data, out_item.data);
					check_field("found", want.found, out_item.found);
					check_field("occupancy", want.occupancy, out_item.occupancy);
				end
			end
		end
		outstanding <= awaited_results.size();
		mismatches <= error_tally;
	end

endmodule

FILE: test/tb_circular_fifo_with_search_core.sv
`timescale 1ns / 1ps

module tb_circular_fifo_with_search_core;
	import cfs_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 1650;
	localparam int PHASES       = 9;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             capacity_we;
	logic [CAP_W-1:0] capacity_wdata;
	logic             in_valid;
	logic             in_stall;
	in_item_t         in_item;
	logic             out_valid;
	logic             out_stall;
	out_item_t        out_item;
	int               mismatches;
	int               outstanding;
	bit               steady;
	logic [VALUE_W-1:0] recent [8] = '{default: '0};
	int               recent_wr = 0;
	logic [CAP_W-1:0] phase_caps [PHASES] = '{5'd31, 5'd1, 5'd2, 5'd16, 5'd7, 5'd17, 5'd4,
		5'd16, 5'd16};

	always #10 clk = ~clk;

	circular_fifo_with_search_core #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(VALUE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.capacity_we(capacity_we),
		.capacity_wdata(capacity_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	fifo_search_checker #(
		.DEPTH(DEPTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.capacity_we(capacity_we),
		.capacity_wdata(capacity_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 25);
	end

	task automatic send_op(op_t op, logic [VALUE_W-1:0] v);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item.operation <= op;
		in_item.value <= v;
		if (op == OP_ENQ) begin
			recent[recent_wr] = v;
			recent_wr = (recent_wr + 1) % 8;
		end
		do @(posedge clk); while (in_stall);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] c);
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);
		@(negedge clk);
		capacity_we <= 1'b1;
		capacity_wdata <= c;
		@(negedge clk);
		capacity_we <= 1'b0;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0: return recent[$urandom_range(0, 7)];
			1: return VALUE_W'($urandom_range(0, 7));
			default: return $urandom;
		endcase
	endfunction

	function automatic op_t pick_op(bit filling);
		int r;
		r = $urandom_range(0, 99);
		if (filling) begin
			if (r < 55) return OP_ENQ;
			if (r < 70) return OP_DEQ;
			if (r < 80) return OP_PEEK;
			return OP_SEARCH;
		end
		if (r < 20) return OP_ENQ;
		if (r < 60) return OP_DEQ;
		if (r < 75) return OP_PEEK;
		return OP_SEARCH;
	endfunction

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		capacity_we = 1'b0;
		capacity_wdata = '0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		steady = 1'b0;
		phase_caps[PHASES-1] = CAP_W'($urandom_range(1, DEPTH));
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_op(OP_PEEK, '0);
		send_op(OP_DEQ, '1);
		send_op(OP_SEARCH, '0);

		set_capacity('0);
		send_op(OP_ENQ, '0);
		send_op(OP_ENQ, '1);
		send_op(OP_SEARCH, '1);
		send_op(OP_SEARCH, '0);
		send_op(OP_PEEK, '0);
		send_op(OP_DEQ, '0);
		send_op(OP_DEQ, '0);
		send_op(OP_ENQ, '1);
		send_op(OP_SEARCH, '1);
		send_op(OP_DEQ, '0);

		set_capacity(CAP_W'(3));
		send_op(OP_ENQ, 32'd1);
		send_op(OP_ENQ, 32'd2);
		send_op(OP_ENQ, 32'd3);
		send_op(OP_ENQ, 32'd4);
		send_op(OP_DEQ, '0);
		send_op(OP_ENQ, 32'ha5a5_a5a5);
		send_op(OP_SEARCH, 32'd1);
		send_op(OP_SEARCH, 32'ha5a5_a5a5);
		send_op(OP_PEEK, '0);
		send_op(OP_DEQ, '0);
		send_op(OP_DEQ, '0);
		send_op(OP_DEQ, '0);

		for (int ph = 0; ph < PHASES; ph++) begin
			steady = (ph == 4);
			set_capacity(phase_caps[ph]);
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
				send_op(pick_op((n / 48) % 2 == 0), pick_value());
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/cfs_pkg.sv
rtl/core/cfs_cell.sv
rtl/core/circular_fifo_with_search_core.sv
rtl/core/cfs_checker.sv
test/fifo_search_checker.sv
test/tb_circular_fifo_with_search_core.sv
